/* src/lvm_pkg.sv */
// shared constants and types for the look-at view matrix block
// widths derive from FRAC_BITS and the 32-bit coordinate width; no dependencies
package lvm_pkg;

  localparam int FRAC_BITS = 16;
  localparam int CW        = 32;                     // coordinate width
  localparam int NW        = FRAC_BITS + 2;          // normalised component, signed
  localparam int UW        = FRAC_BITS + 3;          // true-up component, signed
  localparam int XW        = 2 * NW + 1;             // exact cross product, signed
  localparam int VW        = (XW > CW + 1) ? XW : CW + 1;  // normaliser input
  localparam int POSW      = $clog2(VW);
  localparam int NORM_TOP  = 29;                     // magnitudes brought to [2^29, 2^30)
  localparam int SW        = NORM_TOP + 1;
  localparam int L2W       = 2 * SW + 2;             // sum of three squares
  localparam int SQ_STEPS  = L2W / 2;
  localparam int LW        = SW + 1;                 // vector length
  localparam int QW        = FRAC_BITS + 1;          // quotient bits
  localparam int NUMW      = SW + FRAC_BITS + 1;     // rounded dividend
  localparam int DW        = UW + CW + 2;            // dot product accumulator
  localparam int NORM_LAT  = 5 + SQ_STEPS + 1 + QW + 1;

  typedef logic [2:0][VW-1:0] vin_t;
  typedef logic [2:0][NW-1:0] vnorm_t;

  typedef enum logic [1:0] {
    ROW_SIDE,
    ROW_UP,
    ROW_FWD,
    ROW_W
  } row_e;

endpackage

/* src/lvm_norm.sv */
// pipelined three-component vector normaliser: range shift, squares, root, divide
// depends on lvm_pkg
module lvm_norm import lvm_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   en_i,
  input  logic   vld_i,
  input  vin_t   v_i,
  output vnorm_t o_o,
  output logic   zero_o,
  output logic   vld_o
);

  logic [NORM_LAT-1:0] vld_q;

  // magnitudes and maximum
  logic [2:0][VW-1:0] mag;
  logic [2:0]         sgn;
  logic [VW-1:0]      mx01;
  logic [2:0][VW-1:0] m0_q;
  logic [2:0]         sg0_q;
  logic [VW-1:0]      mx0_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sgn[i] = v_i[i][VW-1];
      mag[i] = sgn[i] ? VW'(-v_i[i]) : v_i[i];
    end
    mx01 = (mag[1] > mag[0]) ? mag[1] : mag[0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m0_q  <= mag;
      sg0_q <= sgn;
      mx0_q <= (mag[2] > mx01) ? mag[2] : mx01;
    end
  end

  // leading one and shift amount
  logic [POSW-1:0]    pos;
  logic [2:0][VW-1:0] m1_q;
  logic [2:0]         sg1_q;
  logic               z1_q, shr1_q;
  logic [POSW-1:0]    amt1_q;

  always_comb begin
    pos = '0;
    for (int i = 0; i < VW; i++) begin
      if (mx0_q[i]) pos = POSW'(i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m1_q   <= m0_q;
      sg1_q  <= sg0_q;
      z1_q   <= (mx0_q == '0);
      shr1_q <= (pos > POSW'(NORM_TOP));
      amt1_q <= (pos > POSW'(NORM_TOP)) ? pos - POSW'(NORM_TOP) : POSW'(NORM_TOP) - pos;
    end
  end

  // group shift
  logic [2:0][SW-1:0] m2_q;
  logic [2:0]         sg2_q;
  logic               z2_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        m2_q[i] <= shr1_q ? SW'(m1_q[i] >> amt1_q) : SW'(m1_q[i] << amt1_q);
      end
      sg2_q <= sg1_q;
      z2_q  <= z1_q;
    end
  end

  // squares
  logic [2:0][2*SW-1:0] sq3_q;
  logic [2:0][SW-1:0]   m3_q;
  logic [2:0]           sg3_q;
  logic                 z3_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        sq3_q[i] <= {{SW{1'b0}}, m2_q[i]} * {{SW{1'b0}}, m2_q[i]};
      end
      m3_q  <= m2_q;
      sg3_q <= sg2_q;
      z3_q  <= z2_q;
    end
  end

  // sum of squares
  logic [L2W-1:0]     l2_4_q;
  logic [2:0][SW-1:0] m4_q;
  logic [2:0]         sg4_q;
  logic               z4_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      l2_4_q <= L2W'(sq3_q[0]) + L2W'(sq3_q[1]) + L2W'(sq3_q[2]);
      m4_q   <= m3_q;
      sg4_q  <= sg3_q;
      z4_q   <= z3_q;
    end
  end

  // integer square root, one result bit per stage
  logic [L2W-1:0]     sq_n_q  [SQ_STEPS];
  logic [L2W-1:0]     sq_r_q  [SQ_STEPS];
  logic [2:0][SW-1:0] sq_m_q  [SQ_STEPS];
  logic [2:0]         sq_sg_q [SQ_STEPS];
  logic               sq_z_q  [SQ_STEPS];

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
    localparam logic [L2W-1:0] BIT = L2W'(1) << (2 * (SQ_STEPS - 1 - k));
    logic [L2W-1:0]     n_in, r_in;
    logic [2:0][SW-1:0] m_in;
    logic [2:0]         sg_in;
    logic               z_in;
    logic [L2W:0]       trial;

    if (k == 0) begin : g_first
      assign n_in  = l2_4_q;
      assign r_in  = '0;
      assign m_in  = m4_q;
      assign sg_in = sg4_q;
      assign z_in  = z4_q;
    end else begin : g_next
      assign n_in  = sq_n_q[k-1];
      assign r_in  = sq_r_q[k-1];
      assign m_in  = sq_m_q[k-1];
      assign sg_in = sq_sg_q[k-1];
      assign z_in  = sq_z_q[k-1];
    end

    assign trial = {1'b0, r_in} + {1'b0, BIT};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if ({1'b0, n_in} >= trial) begin
          sq_n_q[k] <= n_in - trial[L2W-1:0];
          sq_r_q[k] <= (r_in >> 1) + BIT;
        end else begin
          sq_n_q[k] <= n_in;
          sq_r_q[k] <= r_in >> 1;
        end
        sq_m_q[k]  <= m_in;
        sq_sg_q[k] <= sg_in;
        sq_z_q[k]  <= z_in;
      end
    end
  end

  // rounded dividend, split into starting remainder and bits still to bring down
  logic [LW-1:0]         len;
  logic [2:0][NUMW-1:0]  num;
  logic [2:0][LW-1:0]    pr_rem_q;
  logic [2:0][QW-1:0]    pr_low_q;
  logic [LW-1:0]         pr_len_q;
  logic [2:0]            pr_sg_q;
  logic                  pr_z_q;

  assign len = sq_r_q[SQ_STEPS-1][LW-1:0];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num[i] = {NUMW'(sq_m_q[SQ_STEPS-1][i]) << FRAC_BITS} + NUMW'(len >> 1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        pr_rem_q[i] <= LW'(num[i][NUMW-1:QW]);
        pr_low_q[i] <= num[i][QW-1:0];
      end
      pr_len_q <= len;
      pr_sg_q  <= sq_sg_q[SQ_STEPS-1];
      pr_z_q   <= sq_z_q[SQ_STEPS-1];
    end
  end

  // restoring division, one quotient bit per stage
  logic [2:0][LW-1:0] dv_rem_q [QW];
  logic [2:0][QW-1:0] dv_low_q [QW];
  logic [2:0][QW-1:0] dv_quo_q [QW];
  logic [LW-1:0]      dv_len_q [QW];
  logic [2:0]         dv_sg_q  [QW];
  logic               dv_z_q   [QW];

  for (genvar j = 0; j < QW; j++) begin : g_div
    logic [2:0][LW-1:0] rem_in;
    logic [2:0][QW-1:0] low_in, quo_in;
    logic [LW-1:0]      len_in;
    logic [2:0]         sg_in;
    logic               z_in;
    logic [2:0][LW:0]   trial;
    logic [2:0]         ge;

    if (j == 0) begin : g_first
      assign rem_in = pr_rem_q;
      assign low_in = pr_low_q;
      assign quo_in = '0;
      assign len_in = pr_len_q;
      assign sg_in  = pr_sg_q;
      assign z_in   = pr_z_q;
    end else begin : g_next
      assign rem_in = dv_rem_q[j-1];
      assign low_in = dv_low_q[j-1];
      assign quo_in = dv_quo_q[j-1];
      assign len_in = dv_len_q[j-1];
      assign sg_in  = dv_sg_q[j-1];
      assign z_in   = dv_z_q[j-1];
    end

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        trial[i] = {rem_in[i], low_in[i][QW-1-j]};
        ge[i]    = (trial[i] >= {1'b0, len_in});
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        for (int i = 0; i < 3; i++) begin
          dv_rem_q[j][i] <= ge[i] ? LW'(trial[i] - {1'b0, len_in}) : LW'(trial[i]);
          dv_quo_q[j][i] <= {quo_in[i][QW-2:0], ge[i]};
        end
        dv_low_q[j] <= low_in;
        dv_len_q[j] <= len_in;
        dv_sg_q[j]  <= sg_in;
        dv_z_q[j]   <= z_in;
      end
    end
  end

  // sign restore; a zero-length vector stays zero
  vnorm_t o_q;
  logic   z_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        if (dv_z_q[QW-1]) begin
          o_q[i] <= '0;
        end else if (dv_sg_q[QW-1][i]) begin
          o_q[i] <= NW'(-{1'b0, dv_quo_q[QW-1][i]});
        end else begin
          o_q[i] <= NW'({1'b0, dv_quo_q[QW-1][i]});
        end
      end
      z_q <= dv_z_q[QW-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NORM_LAT-2:0], vld_i};
    end
  end

  assign o_o    = o_q;
  assign zero_o = z_q;
  assign vld_o  = vld_q[NORM_LAT-1];

endmodule

/* src/lookat_view_matrix.sv */
// output: row 0 of a Q16.16 matrix appears once the finished matrix is loaded into the row serialiser,
//   rows 1 to 3 follow one per cycle when the output is not stalled
// throughput: sustained input is limited by the four-row output port;
//   the pipeline itself takes one input per cycle until the row serialiser backs up
// reset: asynchronous active low, clears all valid bits; no clearing pass
module lookat_view_matrix import lvm_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic signed [CW-1:0] eye_x_i,
  input  logic signed [CW-1:0] eye_y_i,
  input  logic signed [CW-1:0] eye_z_i,
  input  logic signed [CW-1:0] target_x_i,
  input  logic signed [CW-1:0] target_y_i,
  input  logic signed [CW-1:0] target_z_i,
  input  logic signed [CW-1:0] up_x_i,
  input  logic signed [CW-1:0] up_y_i,
  input  logic signed [CW-1:0] up_z_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [1:0]           row_index_o,
  output logic signed [CW-1:0] col0_o,
  output logic signed [CW-1:0] col1_o,
  output logic signed [CW-1:0] col2_o,
  output logic signed [CW-1:0] col3_o,
  output logic                 last_row_o,
  output logic                 degenerate_o
);

  localparam logic signed [XW-1:0] HALF_X = XW'(1) << (FRAC_BITS - 1);
  localparam logic signed [DW-1:0] HALF_D = DW'(1) << (FRAC_BITS - 1);
  localparam logic signed [DW-1:0] SAT_HI = DW'({1'b0, {(CW-1){1'b1}}});
  localparam logic signed [DW-1:0] SAT_LO = -SAT_HI - DW'(1);
  localparam logic signed [CW-1:0] ONE_Q  = CW'(1) << FRAC_BITS;

  // round half up to FRAC_BITS and clamp to the coordinate range
  function automatic logic signed [CW-1:0] rnd_sat(input logic signed [DW-1:0] acc);
    logic signed [DW-1:0] r;
    r = (acc + HALF_D) >>> FRAC_BITS;
    if (r > SAT_HI) begin
      return SAT_HI[CW-1:0];
    end else if (r < SAT_LO) begin
      return SAT_LO[CW-1:0];
    end
    return r[CW-1:0];
  endfunction

  // one enable for every stage: the pipeline moves unless its last stage is
  // full and the row serialiser cannot take it
  logic en;
  logic v7_q;
  logic load;

  // ---------------------------------------------------------------- stage 0
  // register inputs, form target - eye at full width
  logic                 v0_q;
  logic [2:0][CW-1:0]   eye0_q;
  vin_t                 up0_q, dir0_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      eye0_q    <= {eye_z_i, eye_y_i, eye_x_i};
      up0_q[0]  <= VW'(up_x_i);
      up0_q[1]  <= VW'(up_y_i);
      up0_q[2]  <= VW'(up_z_i);
      dir0_q[0] <= VW'(target_x_i) - VW'(eye_x_i);
      dir0_q[1] <= VW'(target_y_i) - VW'(eye_y_i);
      dir0_q[2] <= VW'(target_z_i) - VW'(eye_z_i);
    end
  end

  // ------------------------------------------- normalise up and forward
  vnorm_t upn, fwd;
  logic   za, zb, va, vb;

  lvm_norm u_norm_up (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (v0_q),
    .v_i    (up0_q),
    .o_o    (upn),
    .zero_o (za),
    .vld_o  (va)
  );

  lvm_norm u_norm_fwd (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (v0_q),
    .v_i    (dir0_q),
    .o_o    (fwd),
    .zero_o (zb),
    .vld_o  (vb)
  );

  // eye travels alongside the normalisers
  logic [2:0][CW-1:0] eye_da_q [NORM_LAT];

  always_ff @(posedge clk_i) begin
    if (en) begin
      eye_da_q[0] <= eye0_q;
      for (int k = 1; k < NORM_LAT; k++) begin
        eye_da_q[k] <= eye_da_q[k-1];
      end
    end
  end

  // ---------------------------------------------------------------- stage 1
  // partial products of f x up
  logic                   v1_q, d1_q;
  logic signed [2*NW-1:0] pa1_q [3];
  logic signed [2*NW-1:0] pb1_q [3];
  vnorm_t                 f1_q;
  logic [2:0][CW-1:0]     e1_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      pa1_q[0] <= $signed(fwd[1]) * $signed(upn[2]);
      pb1_q[0] <= $signed(fwd[2]) * $signed(upn[1]);
      pa1_q[1] <= $signed(fwd[2]) * $signed(upn[0]);
      pb1_q[1] <= $signed(fwd[0]) * $signed(upn[2]);
      pa1_q[2] <= $signed(fwd[0]) * $signed(upn[1]);
      pb1_q[2] <= $signed(fwd[1]) * $signed(upn[0]);
      f1_q     <= fwd;
      e1_q     <= eye_da_q[NORM_LAT-1];
      d1_q     <= za | zb;
    end
  end

  // ---------------------------------------------------------------- stage 2
  // exact cross product at double precision
  logic               v2_q, d2_q;
  vin_t               c2_q;
  vnorm_t             f2_q;
  logic [2:0][CW-1:0] e2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        c2_q[i] <= VW'(XW'(pa1_q[i]) - XW'(pb1_q[i]));
      end
      f2_q <= f1_q;
      e2_q <= e1_q;
      d2_q <= d1_q;
    end
  end

  // ------------------------------------------------------ normalise side
  vnorm_t side;
  logic   zc, vc;

  lvm_norm u_norm_side (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (v2_q),
    .v_i    (c2_q),
    .o_o    (side),
    .zero_o (zc),
    .vld_o  (vc)
  );

  vnorm_t             f_dc_q [NORM_LAT];
  logic [2:0][CW-1:0] e_dc_q [NORM_LAT];
  logic               d_dc_q [NORM_LAT];

  always_ff @(posedge clk_i) begin
    if (en) begin
      f_dc_q[0] <= f2_q;
      e_dc_q[0] <= e2_q;
      d_dc_q[0] <= d2_q;
      for (int k = 1; k < NORM_LAT; k++) begin
        f_dc_q[k] <= f_dc_q[k-1];
        e_dc_q[k] <= e_dc_q[k-1];
        d_dc_q[k] <= d_dc_q[k-1];
      end
    end
  end

  // ---------------------------------------------------------------- stage 3
  // partial products of s x f and of s . eye
  logic                      v3_q, d3_q;
  logic signed [2*NW-1:0]    pa3_q [3];
  logic signed [2*NW-1:0]    pb3_q [3];
  logic signed [NW+CW-1:0]   se3_q [3];
  vnorm_t                    s3_q, f3_q;
  logic [2:0][CW-1:0]        e3_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      pa3_q[0] <= $signed(side[1]) * $signed(f_dc_q[NORM_LAT-1][2]);
      pb3_q[0] <= $signed(side[2]) * $signed(f_dc_q[NORM_LAT-1][1]);
      pa3_q[1] <= $signed(side[2]) * $signed(f_dc_q[NORM_LAT-1][0]);
      pb3_q[1] <= $signed(side[0]) * $signed(f_dc_q[NORM_LAT-1][2]);
      pa3_q[2] <= $signed(side[0]) * $signed(f_dc_q[NORM_LAT-1][1]);
      pb3_q[2] <= $signed(side[1]) * $signed(f_dc_q[NORM_LAT-1][0]);
      for (int i = 0; i < 3; i++) begin
        se3_q[i] <= $signed(side[i]) * $signed(e_dc_q[NORM_LAT-1][i]);
      end
      s3_q <= side;
      f3_q <= f_dc_q[NORM_LAT-1];
      e3_q <= e_dc_q[NORM_LAT-1];
      d3_q <= d_dc_q[NORM_LAT-1] | zc;
    end
  end

  // ---------------------------------------------------------------- stage 4
  // true-up vector rounded back to FRAC_BITS, side dot eye summed
  logic signed [XW-1:0] tt [3];
  logic                 v4_q, d4_q;
  logic signed [UW-1:0] u4_q [3];
  logic signed [DW-1:0] sd4_q;
  vnorm_t               s4_q, f4_q;
  logic [2:0][CW-1:0]   e4_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tt[i] = XW'(pa3_q[i]) - XW'(pb3_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        u4_q[i] <= UW'((tt[i] + HALF_X) >>> FRAC_BITS);
      end
      sd4_q <= DW'(se3_q[0]) + DW'(se3_q[1]) + DW'(se3_q[2]);
      s4_q  <= s3_q;
      f4_q  <= f3_q;
      e4_q  <= e3_q;
      d4_q  <= d3_q;
    end
  end

  // ---------------------------------------------------------------- stage 5
  // products for u . eye and f . eye, side translation finished
  logic                    v5_q, d5_q;
  logic signed [UW+CW-1:0] ue5_q [3];
  logic signed [NW+CW-1:0] fe5_q [3];
  logic signed [CW-1:0]    tr0_5_q;
  vnorm_t                  s5_q, f5_q;
  logic signed [UW-1:0]    u5_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        ue5_q[i] <= u4_q[i] * $signed(e4_q[i]);
        fe5_q[i] <= $signed(f4_q[i]) * $signed(e4_q[i]);
        u5_q[i]  <= u4_q[i];
      end
      tr0_5_q <= rnd_sat(-sd4_q);
      s5_q    <= s4_q;
      f5_q    <= f4_q;
      d5_q    <= d4_q;
    end
  end

  // ---------------------------------------------------------------- stage 6
  logic                 v6_q, d6_q;
  logic signed [DW-1:0] ud6_q, fd6_q;
  logic signed [CW-1:0] tr0_6_q;
  vnorm_t               s6_q, f6_q;
  logic signed [UW-1:0] u6_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      ud6_q   <= DW'(ue5_q[0]) + DW'(ue5_q[1]) + DW'(ue5_q[2]);
      fd6_q   <= DW'(fe5_q[0]) + DW'(fe5_q[1]) + DW'(fe5_q[2]);
      tr0_6_q <= tr0_5_q;
      s6_q    <= s5_q;
      f6_q    <= f5_q;
      u6_q    <= u5_q;
      d6_q    <= d5_q;
    end
  end

  // ---------------------------------------------------------------- stage 7
  // last stage: whole matrix ready
  logic                 d7_q;
  logic signed [CW-1:0] tr0_7_q, tr1_7_q, tr2_7_q;
  vnorm_t               s7_q, f7_q;
  logic signed [UW-1:0] u7_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      tr0_7_q <= tr0_6_q;
      tr1_7_q <= rnd_sat(-ud6_q);
      tr2_7_q <= rnd_sat(fd6_q);
      s7_q    <= s6_q;
      f7_q    <= f6_q;
      u7_q    <= u6_q;
      d7_q    <= d6_q;
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
    end else if (en) begin
      v0_q <= in_valid_i;
      v1_q <= va & vb;
      v2_q <= v1_q;
      v3_q <= vc;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
      v7_q <= v6_q;
    end
  end

  // ------------------------------------------------------ row serialiser
  // holds one finished matrix and shows its rows in order; the next matrix
  // is loaded in the same cycle as row 3 leaves, so rows run back to back
  logic                 ov_q;
  row_e                 row_q;
  logic                 out_take;
  vnorm_t               ms_q, mf_q;
  logic signed [UW-1:0] mu_q [3];
  logic signed [CW-1:0] mt0_q, mt1_q, mt2_q;
  logic                 mdeg_q;

  assign out_take = ov_q && !out_stall_i;
  assign load     = v7_q && (!ov_q || (out_take && row_q == ROW_W));
  assign en       = !v7_q || load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q  <= 1'b0;
      row_q <= ROW_SIDE;
    end else if (load) begin
      ov_q  <= 1'b1;
      row_q <= ROW_SIDE;
    end else if (out_take) begin
      if (row_q == ROW_W) begin
        ov_q <= 1'b0;
      end else begin
        row_q <= row_e'(2'(row_q) + 2'd1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      ms_q   <= s7_q;
      mf_q   <= f7_q;
      mu_q   <= u7_q;
      mt0_q  <= tr0_7_q;
      mt1_q  <= tr1_7_q;
      mt2_q  <= tr2_7_q;
      mdeg_q <= d7_q;
    end
  end

  always_comb begin
    unique case (row_q)
      ROW_SIDE: begin
        col0_o = CW'($signed(ms_q[0]));
        col1_o = CW'($signed(ms_q[1]));
        col2_o = CW'($signed(ms_q[2]));
        col3_o = mt0_q;
      end
      ROW_UP: begin
        col0_o = CW'(mu_q[0]);
        col1_o = CW'(mu_q[1]);
        col2_o = CW'(mu_q[2]);
        col3_o = mt1_q;
      end
      ROW_FWD: begin
        col0_o = CW'(-$signed(mf_q[0]));
        col1_o = CW'(-$signed(mf_q[1]));
        col2_o = CW'(-$signed(mf_q[2]));
        col3_o = mt2_q;
      end
      ROW_W: begin
        col0_o = '0;
        col1_o = '0;
        col2_o = '0;
        col3_o = ONE_Q;
      end
    endcase
  end

  assign in_stall_o   = !en;
  assign out_valid_o  = ov_q;
  assign row_index_o  = row_q;
  assign last_row_o   = (row_q == ROW_W);
  assign degenerate_o = mdeg_q;

endmodule

/* src/lvm_chk.sv */
// port-level checker for the look-at view matrix block, bound to the top level
// depends on lvm_pkg and lookat_view_matrix
module lvm_chk import lvm_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input logic [1:0]           row_index_o,
  input logic signed [CW-1:0] col0_o,
  input logic signed [CW-1:0] col1_o,
  input logic signed [CW-1:0] col2_o,
  input logic signed [CW-1:0] col3_o,
  input logic                 last_row_o,
  input logic                 degenerate_o
);

  // rows of one matrix follow each other without a gap
  a_row_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && row_index_o != ROW_W) |=>
      (out_valid_o && row_index_o == $past(row_index_o) + 2'd1))
    else $error("row sequence broken");

  // a matrix starts at row 0
  a_first_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> (row_index_o == ROW_SIDE))
    else $error("matrix does not start at row 0");

  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_row_o == (row_index_o == ROW_W)))
    else $error("last_row flag wrong");

  // the degenerate flag is one value for the whole matrix
  a_deg_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && row_index_o != ROW_W) |=>
      (degenerate_o == $past(degenerate_o)))
    else $error("degenerate flag changed within a matrix");

  a_const_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && row_index_o == ROW_W) |->
      (col0_o == '0 && col1_o == '0 && col2_o == '0 && col3_o == (CW'(1) << FRAC_BITS)))
    else $error("constant row wrong");

endmodule

bind lookat_view_matrix lvm_chk u_lvm_chk (.*);
